// ----- rtl/core/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define QIDA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// implication whose consequent is checked in the cycle after the antecedent
`define QIDA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ----- rtl/core/qida_pkg.sv -----
package qida_pkg;

  localparam int NumControllersDef = 8;
  localparam int QueueIdsDef       = 64;
  localparam int ProcessSlotsDef   = 16;
  localparam int MaxBatch          = 64;
  localparam logic [6:0] QuotaReset = 7'd32;

  typedef enum logic [1:0] {
    KIND_INIT      = 2'd0,
    KIND_ALLOC     = 2'd1,
    KIND_REL_BEGIN = 2'd2,
    KIND_REL_ID    = 2'd3
  } qida_kind_e;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_BAD_CTRL  = 4'd1,
    ST_ZERO_CNT  = 4'd2,
    ST_QUOTA     = 4'd3,
    ST_FEW_FREE  = 4'd4,
    ST_NOT_HELD  = 4'd5,
    ST_TBL_FULL  = 4'd6,
    ST_LIST_FULL = 4'd7,
    ST_NO_REL    = 4'd8,
    ST_RSVD9     = 4'd9,
    ST_RSVD10    = 4'd10,
    ST_RSVD11    = 4'd11,
    ST_RSVD12    = 4'd12,
    ST_RSVD13    = 4'd13,
    ST_RSVD14    = 4'd14,
    ST_RSVD15    = 4'd15
  } qida_status_e;

  typedef enum logic {
    REG_MAX_PER_PROC = 1'b0,
    REG_ACTIVE_CTRL  = 1'b1
  } qida_reg_e;

  typedef struct packed {
    logic cap;
    logic dec;
    logic init_step;
    logic init_fin;
    logic srch_rd;
    logic srch_chk;
    logic eval;
    logic pop_rd;
    logic pop_adv;
    logic show_pop;
  } qida_cmd_t;

  typedef struct packed {
    qida_kind_e kind;
    logic       ctrl_ok;
    logic       count_zero;
    logic       init_busy;
    logic       srch_end;
    logic       alloc_ok;
    logic       pop_last;
  } qida_sts_t;

endpackage

// ----- rtl/core/qida_ram.sv -----
module qida_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/qida_ctrl.sv -----
module qida_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  qida_pkg::qida_sts_t sts_i,
  output qida_pkg::qida_cmd_t cmd_o
);
  import qida_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DEC  = 9'b000000010,
    S_INIT = 9'b000000100,
    S_SRD  = 9'b000001000,
    S_SCHK = 9'b000010000,
    S_EVAL = 9'b000100000,
    S_EMIT = 9'b001000000,
    S_PRD  = 9'b010000000,
    S_POUT = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_EMIT) || (state_q == S_POUT);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = S_DEC;
        end
      end
      S_DEC: begin
        cmd_o.dec = 1'b1;
        priority if (sts_i.kind == KIND_REL_ID || !sts_i.ctrl_ok) begin
          state_d = S_EMIT;
        end else if (sts_i.kind == KIND_INIT) begin
          state_d = S_INIT;
        end else if (sts_i.kind == KIND_ALLOC && sts_i.count_zero) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_SRD;
        end
      end
      S_INIT: begin
        if (sts_i.init_busy) begin
          cmd_o.init_step = 1'b1;
        end else begin
          cmd_o.init_fin = 1'b1;
          state_d        = S_EMIT;
        end
      end
      S_SRD: begin
        cmd_o.srch_rd = 1'b1;
        state_d       = S_SCHK;
      end
      S_SCHK: begin
        cmd_o.srch_chk = 1'b1;
        state_d        = sts_i.srch_end ? S_EVAL : S_SRD;
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = sts_i.alloc_ok ? S_PRD : S_EMIT;
      end
      S_EMIT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      S_PRD: begin
        cmd_o.pop_rd = 1'b1;
        state_d      = S_POUT;
      end
      S_POUT: begin
        cmd_o.show_pop = 1'b1;
        if (out_ready_i) begin
          cmd_o.pop_adv = 1'b1;
          state_d       = sts_i.pop_last ? S_IDLE : S_PRD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/qida_dp.sv -----
module qida_dp #(
  parameter int NumControllers = qida_pkg::NumControllersDef,
  parameter int QueueIds       = qida_pkg::QueueIdsDef,
  parameter int ProcessSlots   = qida_pkg::ProcessSlotsDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic                   cfg_index_i,
  input  logic [6:0]             cfg_data_i,
  input  logic [1:0]             kind_i,
  input  logic [2:0]             controller_i,
  input  logic [21:0]            pid_i,
  input  logic [6:0]             count_i,
  input  logic [5:0]             queue_id_i,
  input  logic [6:0]             init_count_i,
  input  qida_pkg::qida_cmd_t    cmd_i,
  output qida_pkg::qida_sts_t    sts_o,
  output logic [3:0]             status_o,
  output logic [5:0]             queue_id_out_o,
  output logic                   last_o
);
  import qida_pkg::*;

  localparam int PW   = $clog2(QueueIds);
  localparam int FW   = $clog2(QueueIds + 1);
  localparam int CIW  = (NumControllers > 1) ? $clog2(NumControllers) : 1;
  localparam int SW   = (ProcessSlots > 1) ? $clog2(ProcessSlots) : 1;
  localparam int FD   = NumControllers * QueueIds;
  localparam int OD   = (NumControllers * ProcessSlots > 1) ?
                        NumControllers * ProcessSlots : 2;
  localparam int FAW  = $clog2(FD);
  localparam int OAW  = $clog2(OD);
  localparam int OWW  = 29;

  logic [6:0]     max_q;
  logic [3:0]     act_q;
  qida_kind_e     kind_q;
  logic [2:0]     c_q;
  logic [21:0]    pid_q;
  logic [6:0]     count_q;
  logic [5:0]     qid_q;
  logic [FW-1:0]  nq_q;
  logic [PW-1:0]  head_q [NumControllers];
  logic [PW-1:0]  tail_q [NumControllers];
  logic [FW-1:0]  fill_q [NumControllers];
  logic [OD-1:0]  valid_q;
  logic [6:0]     rem_q;
  logic [CIW-1:0] rc_q;
  logic [FW-1:0]  i_q;
  logic [SW-1:0]  idx_q;
  logic           found_q, freef_q;
  logic [SW-1:0]  slot_q, fslot_q;
  logic [6:0]     held_q;
  logic [6:0]     k_q;
  qida_status_e   status_q;

  logic [CIW-1:0] ci;
  logic [FW-1:0]  fill_c, fill_r;
  logic           ctrl_ok;
  logic           f_we, o_we;
  logic [FAW-1:0] f_waddr, f_raddr;
  logic [5:0]     f_wdata, f_rdata;
  logic [OAW-1:0] o_waddr, o_raddr;
  logic [OWW-1:0] o_wdata, o_rdata;
  logic           hit;
  logic [6:0]     held_eff;
  logic [7:0]     held_sum;
  logic           q_fail, few, tfull, alloc_ok;
  logic           not_held, ovf;
  logic [6:0]     new_held;
  logic [SW-1:0]  slot_sel;
  logic           rel_push;

  function automatic logic [FAW-1:0] fa(input logic [CIW-1:0] c, input logic [PW-1:0] p);
    return FAW'(32'(c) * QueueIds + 32'(p));
  endfunction

  function automatic logic [OAW-1:0] oa(input logic [CIW-1:0] c, input logic [SW-1:0] s);
    return OAW'(32'(c) * ProcessSlots + 32'(s));
  endfunction

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (32'(p) == QueueIds - 1) ? '0 : PW'(32'(p) + 1);
  endfunction

  assign ci      = CIW'(c_q);
  assign fill_c  = fill_q[ci];
  assign fill_r  = fill_q[rc_q];
  assign ctrl_ok = 32'(c_q) < ((32'(act_q) > NumControllers) ? NumControllers : 32'(act_q));

  assign hit      = valid_q[oa(ci, idx_q)] && (o_rdata[OWW-1:7] == pid_q);
  assign held_eff = found_q ? held_q : 7'd0;
  assign held_sum = {1'b0, held_eff} + {1'b0, count_q};
  assign q_fail   = (32'(count_q) > MaxBatch) || (held_sum > {1'b0, max_q});
  assign few      = 32'(fill_c) < 32'(count_q);
  assign tfull    = !found_q && !freef_q;
  assign alloc_ok = !q_fail && !few && !tfull;
  assign not_held = !found_q || (held_q < count_q);
  assign ovf      = (32'(fill_c) + 32'(count_q)) > QueueIds;
  assign new_held = (kind_q == KIND_ALLOC) ? held_sum[6:0] : held_q - count_q;
  assign slot_sel = found_q ? slot_q : fslot_q;
  assign rel_push = cmd_i.dec && (kind_q == KIND_REL_ID) && (rem_q != 7'd0) &&
                    (32'(fill_r) < QueueIds);

  always_comb begin
    f_we    = 1'b0;
    f_waddr = fa(ci, PW'(i_q));
    f_wdata = 6'(i_q);
    if (cmd_i.init_step) begin
      f_we = 1'b1;
    end else if (rel_push) begin
      f_we    = 1'b1;
      f_waddr = fa(rc_q, tail_q[rc_q]);
      f_wdata = qid_q;
    end
  end

  assign f_raddr = fa(ci, head_q[ci]);
  assign o_raddr = oa(ci, idx_q);
  assign o_waddr = oa(ci, slot_sel);
  assign o_wdata = {pid_q, new_held};
  assign o_we    = cmd_i.eval &&
                   (((kind_q == KIND_ALLOC) && alloc_ok) ||
                    ((kind_q == KIND_REL_BEGIN) && !not_held && !ovf));

  qida_ram #(.Width(6), .Depth(FD)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (f_we),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata),
    .re_i    (cmd_i.pop_rd),
    .raddr_i (f_raddr),
    .rdata_o (f_rdata)
  );

  qida_ram #(.Width(OWW), .Depth(OD)) u_owner_ram (
    .clk_i   (clk_i),
    .we_i    (o_we),
    .waddr_i (o_waddr),
    .wdata_i (o_wdata),
    .re_i    (cmd_i.srch_rd),
    .raddr_i (o_raddr),
    .rdata_o (o_rdata)
  );

  // input transaction fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      kind_q  <= qida_kind_e'(kind_i);
      c_q     <= controller_i;
      pid_q   <= pid_i;
      count_q <= count_i;
      qid_q   <= queue_id_i;
      nq_q    <= (32'(init_count_i) > QueueIds) ? FW'(QueueIds) : FW'(init_count_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q    <= QuotaReset;
      act_q    <= '0;
      valid_q  <= '0;
      rem_q    <= '0;
      rc_q     <= '0;
      i_q      <= '0;
      idx_q    <= '0;
      found_q  <= 1'b0;
      freef_q  <= 1'b0;
      slot_q   <= '0;
      fslot_q  <= '0;
      held_q   <= '0;
      k_q      <= '0;
      status_q <= ST_OK;
      for (int n = 0; n < NumControllers; n++) begin
        head_q[n] <= '0;
        tail_q[n] <= '0;
        fill_q[n] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (qida_reg_e'(cfg_index_i))
          REG_MAX_PER_PROC: max_q <= cfg_data_i;
          REG_ACTIVE_CTRL:  act_q <= cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (cmd_i.dec) begin
        found_q <= 1'b0;
        freef_q <= 1'b0;
        idx_q   <= '0;
        i_q     <= '0;
        status_q <= ST_OK;
        if (kind_q == KIND_REL_ID) begin
          if (rem_q == 7'd0) begin
            status_q <= ST_NO_REL;
          end else begin
            rem_q <= rem_q - 7'd1;
            if (rel_push) begin
              tail_q[rc_q] <= ptr_inc(tail_q[rc_q]);
              fill_q[rc_q] <= fill_r + FW'(1);
            end else begin
              status_q <= ST_LIST_FULL;
            end
          end
        end else if (!ctrl_ok) begin
          status_q <= ST_BAD_CTRL;
        end else if (kind_q == KIND_ALLOC && count_q == 7'd0) begin
          status_q <= ST_ZERO_CNT;
        end else if (kind_q == KIND_REL_BEGIN) begin
          rem_q <= '0;
        end
      end
      if (cmd_i.init_step) begin
        i_q <= i_q + FW'(1);
      end
      if (cmd_i.init_fin) begin
        head_q[ci] <= '0;
        tail_q[ci] <= (32'(nq_q) == QueueIds) ? '0 : PW'(nq_q);
        fill_q[ci] <= nq_q;
        for (int s = 0; s < ProcessSlots; s++) begin
          valid_q[oa(ci, SW'(s))] <= 1'b0;
        end
        // init abandons an open release on this controller
        if (rem_q != 7'd0 && rc_q == ci) begin
          rem_q <= '0;
        end
        status_q <= ST_OK;
      end
      if (cmd_i.srch_chk) begin
        if (hit) begin
          found_q <= 1'b1;
          slot_q  <= idx_q;
          held_q  <= o_rdata[6:0];
        end else if (!valid_q[oa(ci, idx_q)] && !freef_q) begin
          freef_q <= 1'b1;
          fslot_q <= idx_q;
        end
        idx_q <= idx_q + SW'(1);
      end
      if (cmd_i.eval) begin
        if (kind_q == KIND_ALLOC) begin
          priority if (q_fail) begin
            status_q <= ST_QUOTA;
          end else if (few) begin
            status_q <= ST_FEW_FREE;
          end else if (tfull) begin
            status_q <= ST_TBL_FULL;
          end else begin
            status_q <= ST_OK;
            valid_q[o_waddr] <= 1'b1;
            k_q <= '0;
          end
        end else begin
          priority if (not_held) begin
            status_q <= ST_NOT_HELD;
          end else if (ovf) begin
            status_q <= ST_LIST_FULL;
          end else begin
            status_q <= ST_OK;
            if (new_held == 7'd0) begin
              valid_q[o_waddr] <= 1'b0;
            end
            rem_q <= count_q;
            rc_q  <= ci;
          end
        end
      end
      if (cmd_i.pop_adv) begin
        head_q[ci] <= ptr_inc(head_q[ci]);
        fill_q[ci] <= fill_c - FW'(1);
        k_q        <= k_q + 7'd1;
      end
    end
  end

  assign sts_o.kind       = kind_q;
  assign sts_o.ctrl_ok    = ctrl_ok;
  assign sts_o.count_zero = (count_q == 7'd0);
  assign sts_o.init_busy  = (i_q < nq_q);
  assign sts_o.srch_end   = hit || (32'(idx_q) == ProcessSlots - 1);
  assign sts_o.alloc_ok   = (kind_q == KIND_ALLOC) && alloc_ok;
  assign sts_o.pop_last   = (k_q == count_q - 7'd1);

  assign status_o       = cmd_i.show_pop ? ST_OK : status_q;
  assign queue_id_out_o = cmd_i.show_pop ? f_rdata : 6'd0;
  assign last_o         = cmd_i.show_pop ? sts_o.pop_last : 1'b1;

endmodule

// ----- rtl/core/queue_id_allocator_with_quota_core.sv -----
// Queue ID allocator: per controller a FIFO free list of queue IDs in one shared RAM and a
// process table (pid and holding) in a second RAM, handled one transaction at a time. Init
// fills the free list with one RAM write per ID. Allocate and release-begin search the
// process table one slot at a time (RAM read, then check) until the pid is found or the
// last of the PROCESS_SLOTS slots is checked; a successful allocate then gives its IDs one
// at a time, each a free list RAM read, then result, held while the sink stalls. Release-id
// and requests rejected at decode (bad controller, zero count on allocate) go from decode
// straight to their result; the other rejections come after the table search. The input
// is taken only once the previous transaction's last result has been delivered.
module queue_id_allocator_with_quota_core #(
  parameter int NUM_CONTROLLERS = qida_pkg::NumControllersDef,
  parameter int QID_COUNT       = qida_pkg::QueueIdsDef,
  parameter int PROCESS_SLOTS   = qida_pkg::ProcessSlotsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // controller[2:0], pid[24:3], count[31:25], queue_id[37:32], queue count[44:38]
  input  logic [47:0] s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // status[3:0], queue_id_out[9:4]
  output logic [15:0] m_axis_tdata,
  output logic        m_axis_tlast
);
  import qida_pkg::*;

  qida_cmd_t  cmd;
  qida_sts_t  sts;
  logic [3:0] status;
  logic [5:0] qid_out;

  qida_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  qida_dp #(
    .NumControllers (NUM_CONTROLLERS),
    .QueueIds       (QID_COUNT),
    .ProcessSlots   (PROCESS_SLOTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .kind_i         (s_axis_tuser),
    .controller_i   (s_axis_tdata[2:0]),
    .pid_i          (s_axis_tdata[24:3]),
    .count_i        (s_axis_tdata[31:25]),
    .queue_id_i     (s_axis_tdata[37:32]),
    .init_count_i   (s_axis_tdata[44:38]),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .status_o       (status),
    .queue_id_out_o (qid_out),
    .last_o         (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, qid_out, status};

endmodule

// ----- rtl/core/qida_checker.sv -----
`include "assert_macros.svh"

module qida_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tlast
);
  import qida_pkg::*;

  // a result waiting for the sink does not vanish
  `QIDA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped")
  // one transaction at a time: no input taken while a result is shown
  `QIDA_ASSERT(a_no_overlap, (s_axis_tvalid && s_axis_tready) |-> !m_axis_tvalid, "overlap")
  `QIDA_ASSERT_NEXT(a_busy_after, s_axis_tvalid && s_axis_tready, !s_axis_tready, "not busy")
  // an error result is a single closing result with no id
  `QIDA_ASSERT(a_err_last, (m_axis_tvalid && m_axis_tdata[3:0] != ST_OK) |-> (m_axis_tlast && m_axis_tdata[9:4] == 6'd0), "bad error result")

endmodule

bind queue_id_allocator_with_quota_core qida_checker u_qida_checker (.*);
